[rtl/cau_pkg.sv]
// types, constants and saturation helper shared by the complex arithmetic unit
package cau_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 8;
    localparam int DEN_W  = 2 * DATA_W;
    localparam int Q_W    = DATA_W + 1;
    localparam int REM_W  = 3 * DATA_W + FRAC_W + 1;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_DIST = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [DEN_W-1:0] HALF_MAG = DEN_W'(1) << (DATA_W - 1);

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic [1:0]               status;
    } cau_out_t;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } cau_sat_t;

    // per-beat control that rides alongside the divider pipeline
    typedef struct packed {
        logic [2:0]        cmd;
        logic              neg_re;
        logic              neg_im;
        logic              den_zero;
        logic              dist_big;
        logic [DATA_W-1:0] res_re;
        logic [DATA_W-1:0] res_im;
        logic              ovf;
    } cau_side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem_re;
        logic [REM_W-1:0]  rem_im;
        logic [DEN_W-1:0]  den;
        logic [Q_W-1:0]    q_re;
        logic [Q_W-1:0]    q_im;
        logic              ovq_re;
        logic              ovq_im;
        logic [DEN_W:0]    sq_rem;
        logic [DATA_W-1:0] root;
    } cau_div_t;

    function automatic cau_sat_t sat_mag(input logic neg, input logic [DEN_W-1:0] mag);
        cau_sat_t r;
        r.ovf = 1'b0;
        if (!neg)
        begin
            if (mag > HALF_MAG - DEN_W'(1))
            begin
                r.ovf = 1'b1;
                r.val = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                r.val = mag[DATA_W-1:0];
            end
        end
        else
        begin
            if (mag > HALF_MAG)
            begin
                r.ovf = 1'b1;
                r.val = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                r.val = DATA_W'(0) - mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

[rtl/cau_divsqrt.sv]
// pipelined restoring divider for both quotient parts plus integer square root
module cau_divsqrt
    import cau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cau_side_t        in_side,
    input  logic [DEN_W-1:0] in_mag_re,
    input  logic [DEN_W-1:0] in_mag_im,
    input  logic [DEN_W-1:0] in_den,
    output logic             out_valid,
    input  logic             out_ready,
    output cau_side_t        out_side,
    output cau_div_t         out_div
);

    localparam int NS = DATA_W + 2;

    logic          v_reg [NS];
    logic [NS:0]   rdy;
    cau_side_t     side_reg [NS];
    cau_div_t      div_reg  [NS];
    cau_div_t      div_next [NS];

    assign rdy[NS] = out_ready;

    // stage 0 scales the dividends and checks for quotient overflow
    always_comb
    begin
        div_next[0].rem_re = REM_W'(in_mag_re) << FRAC_W;
        div_next[0].rem_im = REM_W'(in_mag_im) << FRAC_W;
        div_next[0].den    = in_den;
        div_next[0].q_re   = '0;
        div_next[0].q_im   = '0;
        div_next[0].ovq_re = (REM_W'(in_mag_re) << FRAC_W) >= (REM_W'(in_den) << (DATA_W + 1));
        div_next[0].ovq_im = (REM_W'(in_mag_im) << FRAC_W) >= (REM_W'(in_den) << (DATA_W + 1));
        div_next[0].sq_rem = {1'b0, in_den};
        div_next[0].root   = '0;
    end

    genvar s;
    generate
        for (s = 1; s < NS; s++)
        begin : g_step
            localparam int K = DATA_W + 1 - s;
            logic [REM_W-1:0] dsh;

            assign dsh = REM_W'(div_reg[s-1].den) << K;

            if (K >= 1)
            begin : g_root
                logic [DEN_W:0] trial;

                assign trial = ((DEN_W+1)'(div_reg[s-1].root) << K)
                             + ((DEN_W+1)'(1) << (2 * (K - 1)));

                always_comb
                begin
                    div_next[s] = div_reg[s-1];
                    if (div_reg[s-1].rem_re >= dsh)
                    begin
                        div_next[s].rem_re = div_reg[s-1].rem_re - dsh;
                        div_next[s].q_re[K] = 1'b1;
                    end
                    if (div_reg[s-1].rem_im >= dsh)
                    begin
                        div_next[s].rem_im = div_reg[s-1].rem_im - dsh;
                        div_next[s].q_im[K] = 1'b1;
                    end
                    if (div_reg[s-1].sq_rem >= trial)
                    begin
                        div_next[s].sq_rem = div_reg[s-1].sq_rem - trial;
                        div_next[s].root[K-1] = 1'b1;
                    end
                end
            end
            else
            begin : g_last
                always_comb
                begin
                    div_next[s] = div_reg[s-1];
                    if (div_reg[s-1].rem_re >= dsh)
                    begin
                        div_next[s].rem_re = div_reg[s-1].rem_re - dsh;
                        div_next[s].q_re[K] = 1'b1;
                    end
                    if (div_reg[s-1].rem_im >= dsh)
                    begin
                        div_next[s].rem_im = div_reg[s-1].rem_im - dsh;
                        div_next[s].q_im[K] = 1'b1;
                    end
                end
            end
        end

        for (s = 0; s < NS; s++)
        begin : g_stage
            logic      prev_valid;
            cau_side_t prev_side;

            if (s == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_side  = in_side;
            end
            else
            begin : g_rest
                assign prev_valid = v_reg[s-1];
                assign prev_side  = side_reg[s-1];
            end

            assign rdy[s] = !v_reg[s] || rdy[s+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (rdy[s])
                begin
                    v_reg[s] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s])
                begin
                    side_reg[s] <= prev_side;
                    div_reg[s]  <= div_next[s];
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_div   = div_reg[NS-1];

endmodule

[rtl/complex_arithmetic_unit_core.sv]
// complex arithmetic unit top level: operand stages, products, divider/root and result register
//
// Takes one beat per cycle while req_stall is low and returns one result beat per input
// beat, in order. Every command runs the same pipeline on Q8.8 data: four stages for operand
// sums, the products, their sums, and sign and magnitude, one divider setup stage, one
// restoring step per quotient bit (DATA_W + 1), each but the last also carrying one bit of the
// square root, and the output register. Stalls back up stage by stage and empty stages absorb
// bubbles, so the unit keeps accepting while a result waits at the output until full.
module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  cau_in_t  req_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output cau_out_t rsp_data
);

    localparam int W    = DATA_W;
    localparam int PW   = 2 * DATA_W;
    localparam int SQ_W = 2 * DATA_W + 2;

    logic rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic ds_ready, ds_valid;
    cau_side_t ds_side;
    cau_div_t  ds_div;

    // stage 1: operand sums and differences
    logic                v1_reg;
    logic [2:0]          cmd1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [W:0]   ere1_reg, eim1_reg;
    logic signed [W:0]   ere1_next, eim1_next;
    logic signed [W:0]   ar_x, ai_x, br_x, bi_x;

    assign ar_x = {req_data.a_re[W-1], req_data.a_re};
    assign ai_x = {req_data.a_im[W-1], req_data.a_im};
    assign br_x = {req_data.b_re[W-1], req_data.b_re};
    assign bi_x = {req_data.b_im[W-1], req_data.b_im};

    assign ere1_next = (req_data.command == CMD_ADD) ? ar_x + br_x : ar_x - br_x;
    assign eim1_next = (req_data.command == CMD_ADD) ? ai_x + bi_x : ai_x - bi_x;

    // stage 2: six products, squares take the difference for distance
    logic                 v2_reg;
    logic [2:0]           cmd2_reg;
    logic signed [W:0]    ere2_reg, eim2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [SQ_W-1:0] p4_reg, p5_reg;
    logic signed [W:0]    sx, sy;

    assign sx = (cmd1_reg == CMD_DIST) ? ere1_reg : {br1_reg[W-1], br1_reg};
    assign sy = (cmd1_reg == CMD_DIST) ? eim1_reg : {bi1_reg[W-1], bi1_reg};

    // stage 3: numerators and sum of squares
    logic                v3_reg;
    logic [2:0]          cmd3_reg;
    logic signed [W:0]   ere3_reg, eim3_reg;
    logic signed [PW:0]  nre3_reg, nim3_reg;
    logic [PW-1:0]       den3_reg;
    logic signed [PW:0]  nre3_next, nim3_next;
    logic signed [PW:0]  px0, px1, px2, px3;
    logic [SQ_W:0]       sqsum;

    assign px0 = {p0_reg[PW-1], p0_reg};
    assign px1 = {p1_reg[PW-1], p1_reg};
    assign px2 = {p2_reg[PW-1], p2_reg};
    assign px3 = {p3_reg[PW-1], p3_reg};
    assign nre3_next = (cmd2_reg == CMD_MUL) ? px0 - px1 : px0 + px1;
    assign nim3_next = (cmd2_reg == CMD_MUL) ? px2 + px3 : px3 - px2;
    assign sqsum     = (SQ_W+1)'($unsigned(p4_reg)) + (SQ_W+1)'($unsigned(p5_reg));

    // stage 4: sign and magnitude, results that need no divider
    logic                v4_reg;
    cau_side_t           side4_reg, side4_next;
    logic [PW-1:0]       mre4_reg, mim4_reg, den4_reg;
    logic [PW:0]         mre_full, mim_full;
    logic [W:0]          emag_re, emag_im;
    cau_sat_t            s_are, s_aim, s_mre, s_mim;

    assign mre_full = nre3_reg[PW] ? (PW+1)'(0) - $unsigned(nre3_reg) : $unsigned(nre3_reg);
    assign mim_full = nim3_reg[PW] ? (PW+1)'(0) - $unsigned(nim3_reg) : $unsigned(nim3_reg);
    assign emag_re  = ere3_reg[W] ? (W+1)'(0) - $unsigned(ere3_reg) : $unsigned(ere3_reg);
    assign emag_im  = eim3_reg[W] ? (W+1)'(0) - $unsigned(eim3_reg) : $unsigned(eim3_reg);

    assign s_are = sat_mag(ere3_reg[W], PW'(emag_re));
    assign s_aim = sat_mag(eim3_reg[W], PW'(emag_im));
    assign s_mre = sat_mag(nre3_reg[PW], mre_full[PW-1:0] >> FRAC_W);
    assign s_mim = sat_mag(nim3_reg[PW], mim_full[PW-1:0] >> FRAC_W);

    always_comb
    begin
        side4_next.cmd      = cmd3_reg;
        side4_next.neg_re   = nre3_reg[PW];
        side4_next.neg_im   = nim3_reg[PW];
        side4_next.den_zero = (den3_reg == '0);
        side4_next.dist_big = emag_re[W] | emag_re[W-1] | emag_im[W] | emag_im[W-1];
        side4_next.res_re   = '0;
        side4_next.res_im   = '0;
        side4_next.ovf      = 1'b0;
        unique case (cmd3_reg)
            CMD_ADD, CMD_SUB:
            begin
                side4_next.res_re = s_are.val;
                side4_next.res_im = s_aim.val;
                side4_next.ovf    = s_are.ovf | s_aim.ovf;
            end
            CMD_MUL:
            begin
                side4_next.res_re = s_mre.val;
                side4_next.res_im = s_mim.val;
                side4_next.ovf    = s_mre.ovf | s_mim.ovf;
            end
            default:
            begin
                side4_next.ovf = 1'b0;
            end
        endcase
    end

    cau_divsqrt u_divsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (ds_ready),
        .in_side   (side4_reg),
        .in_mag_re (mre4_reg),
        .in_mag_im (mim4_reg),
        .in_den    (den4_reg),
        .out_valid (ds_valid),
        .out_ready (rdy_o),
        .out_side  (ds_side),
        .out_div   (ds_div)
    );

    // output stage: final selection and saturation
    logic          rsp_valid_reg;
    cau_out_t      rsp_data_reg, rsp_data_next;
    cau_sat_t      s_dre, s_dim, s_root;
    logic [PW-1:0] q_re_sel, q_im_sel;
    logic          ovf_fin;

    assign q_re_sel = ds_div.ovq_re ? (PW'(1) << W) : PW'(ds_div.q_re);
    assign q_im_sel = ds_div.ovq_im ? (PW'(1) << W) : PW'(ds_div.q_im);
    assign s_dre    = sat_mag(ds_side.neg_re, q_re_sel);
    assign s_dim    = sat_mag(ds_side.neg_im, q_im_sel);
    assign s_root   = sat_mag(1'b0, PW'(ds_div.root));

    always_comb
    begin
        rsp_data_next.res_re = '0;
        rsp_data_next.res_im = '0;
        rsp_data_next.status = ST_OK;
        ovf_fin              = 1'b0;
        unique case (ds_side.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL:
            begin
                rsp_data_next.res_re = ds_side.res_re;
                rsp_data_next.res_im = ds_side.res_im;
                ovf_fin              = ds_side.ovf;
            end
            CMD_DIV:
            begin
                if (ds_side.den_zero)
                begin
                    rsp_data_next.status = ST_DZ;
                end
                else
                begin
                    rsp_data_next.res_re = s_dre.val;
                    rsp_data_next.res_im = s_dim.val;
                    ovf_fin              = s_dre.ovf | s_dim.ovf;
                end
            end
            CMD_DIST:
            begin
                if (ds_side.dist_big)
                begin
                    rsp_data_next.res_re = {1'b0, {(W-1){1'b1}}};
                    ovf_fin              = 1'b1;
                end
                else
                begin
                    rsp_data_next.res_re = s_root.val;
                    ovf_fin              = s_root.ovf;
                end
            end
            default:
            begin
                ovf_fin = 1'b0;
            end
        endcase
        if (ovf_fin && (rsp_data_next.status == ST_OK))
        begin
            rsp_data_next.status = ST_OVF;
        end
    end

    // backpressure: a stage moves when it is empty or the next one moves
    assign rdy_o = !rsp_valid_reg || !rsp_stall;
    assign rdy4  = !v4_reg || ds_ready;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;

    assign req_stall = !rdy1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy_o)
            begin
                rsp_valid_reg <= ds_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            cmd1_reg <= req_data.command;
            ar1_reg  <= req_data.a_re;
            ai1_reg  <= req_data.a_im;
            br1_reg  <= req_data.b_re;
            bi1_reg  <= req_data.b_im;
            ere1_reg <= ere1_next;
            eim1_reg <= eim1_next;
        end
        if (rdy2)
        begin
            cmd2_reg <= cmd1_reg;
            ere2_reg <= ere1_reg;
            eim2_reg <= eim1_reg;
            p0_reg   <= ar1_reg * br1_reg;
            p1_reg   <= ai1_reg * bi1_reg;
            p2_reg   <= ar1_reg * bi1_reg;
            p3_reg   <= ai1_reg * br1_reg;
            p4_reg   <= SQ_W'(sx) * SQ_W'(sx);
            p5_reg   <= SQ_W'(sy) * SQ_W'(sy);
        end
        if (rdy3)
        begin
            cmd3_reg <= cmd2_reg;
            ere3_reg <= ere2_reg;
            eim3_reg <= eim2_reg;
            nre3_reg <= nre3_next;
            nim3_reg <= nim3_next;
            den3_reg <= sqsum[PW-1:0];
        end
        if (rdy4)
        begin
            side4_reg <= side4_next;
            mre4_reg  <= mre_full[PW-1:0];
            mim4_reg  <= mim_full[PW-1:0];
            den4_reg  <= den3_reg;
        end
        if (rdy_o)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

`ifndef SYNTHESIS
    // the input only stalls when the first stage is holding a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> v1_reg)
        else $error("input stalled with empty first stage");

    // a zero divisor always leaves zero parts
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status == ST_DZ) |-> (rsp_data.res_re == '0 && rsp_data.res_im == '0))
        else $error("divide by zero with nonzero result");

    // status code three is never produced
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_DZ
                       || rsp_data.status == ST_OVF))
        else $error("illegal status");

    // a beat waiting at the output is not replaced by the divider
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data_reg)))
        else $error("output register overwritten while stalled");
`endif

endmodule
